// File: src/scbb_pkg.sv
package scbb_pkg;

    localparam int unsigned ENTRIES_DEF  = 16;
    localparam int unsigned KEY_BITS_DEF = 64;
    localparam int unsigned KEY_W        = 64;
    localparam int unsigned BYTES_W      = 24;
    localparam int unsigned POS_W        = 4;
    localparam int unsigned KIND_W       = 2;

    localparam logic [BYTES_W-1:0] CAP_RESET = 24'd1049000;

    typedef enum logic [KIND_W-1:0] {
        K_LOOKUP = 2'd0,
        K_EVICT  = 2'd1,
        K_INSERT = 2'd2,
        K_REJECT = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_EV_CHECK,
        S_VSCAN,
        S_EV_RD,
        S_EV_CAP,
        S_SHIFT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_VIC,
        RD_SHIFT
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_HIT,
        RES_MISS,
        RES_REJ,
        RES_EVICT,
        RES_INSERT
    } t_res_op;

    typedef struct packed {
        logic    req_load;
        logic    idx_clr;
        logic    scan_step;
        logic    vscan_step;
        logic    shift_step;
        logic    count_dec;
        logic    out_load;
        t_rd_sel rd_sel;
        t_res_op res_op;
    } t_cmd;

    typedef struct packed {
        logic req_mode;
        logic too_big;
        logic hit;
        logic miss;
        logic need_evict;
        logic vic_found;
        logic shift_more;
        logic out_free;
    } t_sts;

endpackage

// File: src/scbb_if.sv
interface scbb_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [scbb_pkg::KEY_W-1:0]   key;
    logic [scbb_pkg::BYTES_W-1:0] object_bytes;

    modport source (output valid, output mode, output key, output object_bytes, input ready);
    modport sink   (input valid, input mode, input key, input object_bytes, output ready);
endinterface

interface scbb_res_if;
    logic                         valid;
    logic                         ready;
    logic [scbb_pkg::KIND_W-1:0]  kind;
    logic                         hit;
    logic [scbb_pkg::POS_W-1:0]   position;
    logic [scbb_pkg::KEY_W-1:0]   entry_key;
    logic [scbb_pkg::BYTES_W-1:0] entry_bytes;
    logic                         last;

    modport source (output valid, output kind, output hit, output position,
                    output entry_key, output entry_bytes, output last, input ready);
    modport sink   (input valid, input kind, input hit, input position,
                    input entry_key, input entry_bytes, input last, output ready);
endinterface

interface scbb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [scbb_pkg::BYTES_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/scbb_dp.sv
module scbb_dp #(
    parameter int unsigned ENTRIES  = scbb_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS = scbb_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scbb_pkg::t_cmd               i_cmd,
    output scbb_pkg::t_sts               o_sts,
    input  logic                         i_req_mode,
    input  logic [scbb_pkg::KEY_W-1:0]   i_req_key,
    input  logic [scbb_pkg::BYTES_W-1:0] i_req_bytes,
    input  logic                         i_cfg_valid,
    input  logic [scbb_pkg::BYTES_W-1:0] i_cfg_data,
    input  logic                         i_res_ready,
    output logic                         o_res_valid,
    output logic [scbb_pkg::KIND_W-1:0]  o_res_kind,
    output logic                         o_res_hit,
    output logic [scbb_pkg::POS_W-1:0]   o_res_position,
    output logic [scbb_pkg::KEY_W-1:0]   o_res_entry_key,
    output logic [scbb_pkg::BYTES_W-1:0] o_res_entry_bytes,
    output logic                         o_res_last
);
    import scbb_pkg::*;

    localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
    localparam int unsigned SCAN_W = CNT_W + 1;
    localparam int unsigned WORD_W = KEY_BITS + BYTES_W;

    logic [WORD_W-1:0]   r_mem [ENTRIES];
    logic [WORD_W-1:0]   r_rdata;
    logic [IDX_W-1:0]    rd_addr;

    logic [BYTES_W-1:0]  r_cap;
    logic [CNT_W-1:0]    r_count;
    logic [BYTES_W-1:0]  r_total;
    logic [ENTRIES-1:0]  r_ref;
    logic [ENTRIES-1:0]  ref_up;

    logic                r_req_mode;
    logic [KEY_BITS-1:0] r_req_key;
    logic [BYTES_W-1:0]  r_req_bytes;

    logic [SCAN_W-1:0]   r_idx;
    logic [SCAN_W-1:0]   idx_p1;
    logic [SCAN_W-1:0]   count_x;
    logic [IDX_W-1:0]    idx_lo;
    logic [IDX_W-1:0]    cnt_lo;
    logic                r_cv;
    logic [IDX_W-1:0]    r_cidx;
    logic [IDX_W-1:0]    r_vic;
    logic                r_wp;
    logic [IDX_W-1:0]    r_widx;

    logic [KEY_BITS-1:0] rd_key;
    logic [BYTES_W-1:0]  rd_bytes;
    logic                all_set;
    logic                vic_found;
    logic                shift_more;
    logic [BYTES_W:0]    sum_need;

    t_kind               r_res_kind;
    logic                r_res_hit;
    logic [POS_W-1:0]    r_res_pos;
    logic [KEY_W-1:0]    r_res_key;
    logic [BYTES_W-1:0]  r_res_bytes;
    logic                r_res_last;

    logic                r_ovalid;
    t_kind               r_o_kind;
    logic                r_o_hit;
    logic [POS_W-1:0]    r_o_pos;
    logic [KEY_W-1:0]    r_o_key;
    logic [BYTES_W-1:0]  r_o_bytes;
    logic                r_o_last;

    assign idx_p1     = r_idx + SCAN_W'(1);
    assign count_x    = SCAN_W'(r_count);
    assign idx_lo     = r_idx[IDX_W-1:0];
    assign cnt_lo     = IDX_W'(r_count);
    assign rd_key     = r_rdata[WORD_W-1:BYTES_W];
    assign rd_bytes   = r_rdata[BYTES_W-1:0];
    assign ref_up     = {1'b0, r_ref[ENTRIES-1:1]};
    assign all_set    = (r_idx == count_x);
    assign vic_found  = all_set || !r_ref[idx_lo];
    assign shift_more = (idx_p1 < count_x);
    assign sum_need   = {1'b0, r_total} + {1'b0, r_req_bytes};

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_SCAN:  rd_addr = idx_lo;
            RD_VIC:   rd_addr = r_vic;
            RD_SHIFT: rd_addr = idx_p1[IDX_W-1:0];
            default:  rd_addr = idx_lo;
        endcase
    end

    always_comb begin
        o_sts.req_mode   = r_req_mode;
        o_sts.too_big    = (r_req_bytes > r_cap);
        o_sts.hit        = r_cv && (rd_key == r_req_key);
        o_sts.miss       = !r_cv && (r_idx >= count_x);
        o_sts.need_evict = (r_count != '0) &&
                           ((sum_need > {1'b0, r_cap}) || (r_count == CNT_W'(ENTRIES)));
        o_sts.vic_found  = vic_found;
        o_sts.shift_more = shift_more;
        o_sts.out_free   = !r_ovalid || i_res_ready;
    end

    // entry store: one write port (append or compaction), one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_op == RES_INSERT) begin
            r_mem[cnt_lo] <= {r_req_key, r_req_bytes};
        end else if (r_wp) begin
            r_mem[r_widx] <= r_rdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_count  <= '0;
            r_total  <= '0;
            r_ref    <= '0;
            r_ovalid <= 1'b0;
            r_cv     <= 1'b0;
            r_wp     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.idx_clr) begin
                r_cv <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cv <= (r_idx < count_x);
            end
            if (i_cmd.idx_clr) begin
                r_wp <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_wp <= shift_more;
            end
            if (i_cmd.count_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.vscan_step && !vic_found) begin
                r_ref[idx_lo] <= 1'b0;
            end
            unique case (i_cmd.res_op)
                RES_HIT: begin
                    r_ref[r_cidx] <= 1'b1;
                end
                RES_EVICT: begin
                    r_total <= (rd_bytes > r_total) ? '0 : r_total - rd_bytes;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IDX_W'(i) >= r_vic) begin
                            r_ref[i] <= ref_up[i];
                        end
                    end
                end
                RES_INSERT: begin
                    r_ref[cnt_lo] <= 1'b1;
                    r_count       <= r_count + CNT_W'(1);
                    r_total       <= r_total + r_req_bytes;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req_mode  <= i_req_mode;
            r_req_key   <= i_req_key[KEY_BITS-1:0];
            r_req_bytes <= i_req_bytes;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= idx_p1;
        end else if (i_cmd.vscan_step && !vic_found) begin
            r_idx <= idx_p1;
        end else if (i_cmd.shift_step && shift_more) begin
            r_idx <= idx_p1;
        end else if (i_cmd.res_op == RES_EVICT) begin
            r_idx <= SCAN_W'(r_vic);
        end
        if (i_cmd.scan_step) begin
            r_cidx <= idx_lo;
        end
        if (i_cmd.vscan_step && vic_found) begin
            r_vic <= all_set ? '0 : idx_lo;
        end
        if (i_cmd.shift_step && shift_more) begin
            r_widx <= idx_lo;
        end
        unique case (i_cmd.res_op)
            RES_HIT: begin
                r_res_kind  <= K_LOOKUP;
                r_res_hit   <= 1'b1;
                r_res_pos   <= POS_W'(r_cidx);
                r_res_key   <= KEY_W'(rd_key);
                r_res_bytes <= rd_bytes;
                r_res_last  <= 1'b1;
            end
            RES_MISS: begin
                r_res_kind  <= K_LOOKUP;
                r_res_hit   <= 1'b0;
                r_res_pos   <= '0;
                r_res_key   <= '0;
                r_res_bytes <= '0;
                r_res_last  <= 1'b1;
            end
            RES_REJ: begin
                r_res_kind  <= K_REJECT;
                r_res_hit   <= 1'b0;
                r_res_pos   <= '0;
                r_res_key   <= KEY_W'(r_req_key);
                r_res_bytes <= r_req_bytes;
                r_res_last  <= 1'b1;
            end
            RES_EVICT: begin
                r_res_kind  <= K_EVICT;
                r_res_hit   <= 1'b0;
                r_res_pos   <= POS_W'(r_vic);
                r_res_key   <= KEY_W'(rd_key);
                r_res_bytes <= rd_bytes;
                r_res_last  <= 1'b0;
            end
            RES_INSERT: begin
                r_res_kind  <= K_INSERT;
                r_res_hit   <= 1'b0;
                r_res_pos   <= POS_W'(r_count);
                r_res_key   <= KEY_W'(r_req_key);
                r_res_bytes <= r_req_bytes;
                r_res_last  <= 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_o_kind  <= r_res_kind;
            r_o_hit   <= r_res_hit;
            r_o_pos   <= r_res_pos;
            r_o_key   <= r_res_key;
            r_o_bytes <= r_res_bytes;
            r_o_last  <= r_res_last;
        end
    end

    assign o_res_valid       = r_ovalid;
    assign o_res_kind        = r_o_kind;
    assign o_res_hit         = r_o_hit;
    assign o_res_position    = r_o_pos;
    assign o_res_entry_key   = r_o_key;
    assign o_res_entry_bytes = r_o_bytes;
    assign o_res_last        = r_o_last;

endmodule

// File: src/scbb_ctrl.sv
module scbb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  scbb_pkg::t_sts i_sts,
    output scbb_pkg::t_cmd o_cmd
);
    import scbb_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state r_after;
    t_state n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (!i_sts.req_mode) begin
                    if (i_sts.hit || i_sts.miss) begin
                        n_state = S_EMIT;
                        n_after = S_IDLE;
                    end
                end else begin
                    n_state = S_EV_CHECK;
                end
            end
            S_EV_CHECK: begin
                if (i_sts.too_big || !i_sts.need_evict) begin
                    n_state = S_EMIT;
                    n_after = S_IDLE;
                end else begin
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                if (i_sts.vic_found) begin
                    n_state = S_EV_RD;
                end
            end
            S_EV_RD: n_state = S_EV_CAP;
            S_EV_CAP: begin
                n_state = S_EMIT;
                n_after = S_SHIFT;
            end
            S_SHIFT: begin
                if (!i_sts.shift_more) begin
                    n_state = S_EV_CHECK;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = r_after;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_SCAN;
        o_cmd.res_op = RES_NONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.req_load = i_in_valid;
                o_cmd.idx_clr  = i_in_valid;
            end
            S_LOOKUP: begin
                // an insert passes straight on to the budget check
                if (!i_sts.req_mode) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.hit) begin
                        o_cmd.res_op = RES_HIT;
                    end else if (i_sts.miss) begin
                        o_cmd.res_op = RES_MISS;
                    end
                end
            end
            S_EV_CHECK: begin
                priority if (i_sts.too_big) begin
                    o_cmd.res_op = RES_REJ;
                end else if (i_sts.need_evict) begin
                    o_cmd.idx_clr = 1'b1;
                end else begin
                    o_cmd.res_op = RES_INSERT;
                end
            end
            S_VSCAN: o_cmd.vscan_step = 1'b1;
            S_EV_RD: o_cmd.rd_sel = RD_VIC;
            S_EV_CAP: o_cmd.res_op = RES_EVICT;
            S_SHIFT: begin
                o_cmd.rd_sel     = RD_SHIFT;
                o_cmd.shift_step = 1'b1;
                o_cmd.count_dec  = !i_sts.shift_more;
            end
            S_EMIT: o_cmd.out_load = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

// File: src/second_chance_byte_budget_cache_top.sv
// Second-chance object cache with a byte budget.
//
// Channels: i_req carries one transaction per request (mode 0 lookup, mode 1 insert,
// key, object_bytes). o_res returns one or more result transactions per request; the
// final one has last set. i_cfg writes capacity_bytes and is always ready; write it only
// while no request is in flight.
// Flow: a lookup scans the entries in age order until it hits or passes the last one.
// An insert with no eviction passes a budget check; each eviction adds a budget check,
// the victim scan (one reference bit per cycle), a read of the victim, a load of the
// eviction result and a compaction that copies one entry per cycle down the age order.
// Throughput: one request at a time; the next is taken once the last result is loaded
// into the output register.
// Reset clears the entry count, byte total and reference bits and restores the budget
// to 1049000; stored keys and sizes are left as they are.
// A stalled receiver holds the output register; the sequencer waits before loading the
// next result, so no result is dropped.
module second_chance_byte_budget_cache_top #(
    parameter int unsigned ENTRIES  = scbb_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS = scbb_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scbb_req_if.sink          i_req,
    scbb_res_if.source        o_res,
    scbb_cfg_if.sink          i_cfg
);
    import scbb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // sequencer: walks lookup scan, victim search, eviction and append
    scbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // entry store, reference bits, byte total and output register
    scbb_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_req_mode        (i_req.mode),
        .i_req_key         (i_req.key),
        .i_req_bytes       (i_req.object_bytes),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_res_ready       (o_res.ready),
        .o_res_valid       (o_res.valid),
        .o_res_kind        (o_res.kind),
        .o_res_hit         (o_res.hit),
        .o_res_position    (o_res.position),
        .o_res_entry_key   (o_res.entry_key),
        .o_res_entry_bytes (o_res.entry_bytes),
        .o_res_last        (o_res.last)
    );

    assign i_req.ready = w_in_ready;
    // budget register takes every write
    assign i_cfg.ready = 1'b1;

endmodule

// File: dv/tb_scbb_ifs.sv
`timescale 1ns / 1ps

// Testbench-side copies are not needed; the RTL interfaces are used directly.
// This file holds a small bundle of shared testbench types.
package tb_scbb_types;
    import scbb_pkg::*;

    typedef struct {
        t_kind                kind;
        logic                 hit;
        logic [POS_W-1:0]     position;
        logic [KEY_W-1:0]     entry_key;
        logic [BYTES_W-1:0]   entry_bytes;
        logic                 last;
    } t_cache_result;
endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps

// Checks the second-chance byte-budget cache against a behavioral predictor.
// Requests are driven through the request channel, results are scored in order.
module tb_top;
    import scbb_pkg::*;
    import tb_scbb_types::*;

    localparam int NSLOT     = 16;
    localparam int CYC_LIMIT = 1500000;
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    logic i_clk;
    logic i_rst_n;

    scbb_req_if req_ch ();
    scbb_res_if res_ch ();
    scbb_cfg_if cfg_ch ();

    second_chance_byte_budget_cache_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Clock: 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor state: mirror of the cache contents in age order.
    logic [KEY_W-1:0]   mirror_keys [NSLOT];
    logic [BYTES_W-1:0] mirror_sizes[NSLOT];
    logic               mirror_refs [NSLOT];
    int unsigned        mirror_count;
    logic [BYTES_W-1:0] mirror_total;
    logic [BYTES_W-1:0] budget;

    t_cache_result pending_results[$];

    int errors;
    int n_results;
    int n_evictions;
    int n_hits;
    int n_rejects;
    longint cycles;
    bit hold_off;   // set by a test to freeze the receiver for a long stretch

    // Queue one expected result; last flag is fixed up by the caller.
    function automatic void push_result(t_kind kind, logic hit, int unsigned pos,
                                        logic [KEY_W-1:0] key, logic [BYTES_W-1:0] bytes);
        t_cache_result r;
        r.kind        = kind;
        r.hit         = hit;
        r.position    = pos[POS_W-1:0];
        r.entry_key   = key;
        r.entry_bytes = bytes;
        r.last        = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Second-chance victim choice; clears reference bits it passes over.
    function automatic int unsigned choose_victim();
        for (int unsigned i = 0; i < mirror_count; i++) begin
            if (mirror_refs[i]) begin
                mirror_refs[i] = 1'b0;
            end else begin
                return i;
            end
        end
        return 0;
    endfunction

    // Work out every result one request causes and update the mirror.
    function automatic void predict_request(logic mode, logic [KEY_W-1:0] key,
                                            logic [BYTES_W-1:0] bytes);
        int unsigned v;
        int unsigned first;
        logic found;
        logic [24:0] sum;
        first = pending_results.size();
        found = 1'b0;
        if (mode == MODE_LOOKUP) begin
            for (int unsigned i = 0; i < mirror_count && !found; i++) begin
                if (mirror_keys[i] == key) begin
                    mirror_refs[i] = 1'b1;
                    push_result(K_LOOKUP, 1'b1, i, mirror_keys[i], mirror_sizes[i]);
                    found = 1'b1;
                end
            end
            if (!found) begin
                push_result(K_LOOKUP, 1'b0, 0, '0, '0);
            end
        end else if (bytes > budget) begin
            push_result(K_REJECT, 1'b0, 0, key, bytes);
        end else begin
            forever begin
                sum = {1'b0, mirror_total} + {1'b0, bytes};
                if (!(mirror_count > 0 && (sum > {1'b0, budget} || mirror_count >= NSLOT)))
                    break;
                v = choose_victim();
                push_result(K_EVICT, 1'b0, v, mirror_keys[v], mirror_sizes[v]);
                mirror_total = (mirror_sizes[v] > mirror_total) ? '0
                             : mirror_total - mirror_sizes[v];
                // Close the gap, keeping age order.
                for (int unsigned i = v; i + 1 < mirror_count; i++) begin
                    mirror_keys[i]  = mirror_keys[i+1];
                    mirror_sizes[i] = mirror_sizes[i+1];
                    mirror_refs[i]  = mirror_refs[i+1];
                end
                mirror_count--;
            end
            mirror_keys[mirror_count]  = key;
            mirror_sizes[mirror_count] = bytes;
            mirror_refs[mirror_count]  = 1'b1;
            push_result(K_INSERT, 1'b0, mirror_count, key, bytes);
            mirror_count++;
            mirror_total = mirror_total + bytes;
        end
        pending_results[pending_results.size()-1].last = 1'b1;
        if (pending_results.size() - first > 0) begin
            for (int unsigned i = first; i < pending_results.size(); i++) begin
                if (pending_results[i].kind == K_EVICT) n_evictions++;
                if (pending_results[i].hit) n_hits++;
                if (pending_results[i].kind == K_REJECT) n_rejects++;
            end
        end
    endfunction

    // Random idle gap: mostly short, sometimes long.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one request; prediction happens on the accepting edge. Valid stays high
    // after the accept so that a request with no gap follows at once; a gap or the
    // end of a burst drops it.
    task automatic send_request(logic mode, logic [KEY_W-1:0] key, logic [BYTES_W-1:0] bytes);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.key          <= key;
        req_ch.object_bytes <= bytes;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(mode, key, bytes);
    endtask

    // Hold until every expected result is back, then let the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Write the budget register while the block is idle.
    task automatic write_budget(logic [BYTES_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        budget = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus a long freeze while hold_off is set.
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 1'b0;
            end else begin
                stall = idle_gap();
                if (stall != 0 && $urandom_range(0, 3) != 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: compare each accepted transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_cache_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d key=%h", $time, res_ch.kind,
                         res_ch.entry_key);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_ch.kind !== exp_r.kind || res_ch.hit !== exp_r.hit ||
                    res_ch.position !== exp_r.position ||
                    res_ch.entry_key !== exp_r.entry_key ||
                    res_ch.entry_bytes !== exp_r.entry_bytes ||
                    res_ch.last !== exp_r.last) begin
                    $display("%0t: expected kind=%0d hit=%0b pos=%0d key=%h bytes=%0d last=%0b",
                             $time, exp_r.kind, exp_r.hit, exp_r.position, exp_r.entry_key,
                             exp_r.entry_bytes, exp_r.last);
                    $display("%0t: actual   kind=%0d hit=%0b pos=%0d key=%h bytes=%0d last=%0b",
                             $time, res_ch.kind, res_ch.hit, res_ch.position,
                             res_ch.entry_key, res_ch.entry_bytes, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run at a generous cycle limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("second_chance_byte_budget_cache_top: mismatch");
            $finish;
        end
    end

    // Pick a key: either one recently used or a fresh random one.
    logic [KEY_W-1:0] key_pool[8];

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 2) != 0) return key_pool[$urandom_range(0, 7)];
        return {$urandom(), $urandom()};
    endfunction

    // Directed: field extremes, lookups that hit and miss, duplicates.
    task automatic test_directed_basics();
        send_request(MODE_LOOKUP, '0, '0);                     // lookup on empty cache
        send_request(MODE_INSERT, '0, '0);                     // zero-size object
        send_request(MODE_INSERT, '1, 24'd1000);
        send_request(MODE_INSERT, 64'h5555_AAAA_5555_AAAA, 24'd1049000);  // forces evictions
        send_request(MODE_INSERT, 64'hAAAA_5555_AAAA_5555, 24'hFFFFFF);   // too large
        send_request(MODE_LOOKUP, 64'h5555_AAAA_5555_AAAA, 24'hFFFFFF);   // hit, size ignored
        send_request(MODE_LOOKUP, '1, '0);                                // evicted, miss
        send_request(MODE_INSERT, 64'h5555_AAAA_5555_AAAA, 24'd1);        // duplicate key
        send_request(MODE_LOOKUP, 64'h5555_AAAA_5555_AAAA, '0);           // hit; the old copy was evicted
    endtask

    // Directed: fill all slots, then lower budget below contents.
    task automatic test_full_and_shrink();
        write_budget(24'hFFFFFF);
        for (int i = 0; i < 17; i++) send_request(MODE_INSERT, 64'(i + 100), 24'(i * 16));
        send_request(MODE_LOOKUP, 64'd105, '0);
        write_budget(24'd50);
        send_request(MODE_INSERT, 64'hDEAD, 24'd50);      // evicts everything else
        write_budget('0);
        send_request(MODE_INSERT, 64'hBEEF, 24'd1);       // rejected
        send_request(MODE_INSERT, 64'hBEEF, 24'd0);
    endtask

    // Random traffic under the given budget, mostly small sizes.
    task automatic test_random_mix(int unsigned count, logic [BYTES_W-1:0] cap);
        logic mode;
        logic [BYTES_W-1:0] bytes;
        logic [KEY_W-1:0] key;
        write_budget(cap);
        for (int unsigned n = 0; n < count; n++) begin
            mode = $urandom_range(0, 1);
            key = pick_key();
            case ($urandom_range(0, 9))
                0:       bytes = 24'($urandom());
                1:       bytes = cap;
                default: bytes = 24'($urandom_range(0, 32'(cap) / 6 + 1));
            endcase
            if (mode == MODE_INSERT) key_pool[$urandom_range(0, 7)] = key;
            send_request(mode, key, bytes);
        end
    endtask

    // Long receiver freeze while requests keep coming; then pause for full drain and send more lookups.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_request(i[0] ? MODE_LOOKUP : MODE_INSERT, pick_key(),
                                 24'($urandom_range(0, 300)));
                req_ch.valid <= 1'b0;
            end
        join
        while (pending_results.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 8; i++) send_request(MODE_LOOKUP, pick_key(), '0);
    endtask

    initial begin
        errors = 0; n_results = 0; n_evictions = 0; n_hits = 0; n_rejects = 0;
        cycles = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = 1'b0;
        req_ch.key = '0;
        req_ch.object_bytes = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        mirror_count = 0;
        mirror_total = '0;
        budget = CAP_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            mirror_keys[i] = '0; mirror_sizes[i] = '0; mirror_refs[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom(), $urandom()};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_full_and_shrink();
        test_random_mix(90, 24'd1000);
        test_random_mix(60, 24'hFFFFFF);
        test_backpressure();
        test_random_mix(60, 24'd300);
        test_random_mix(30, CAP_RESET);

        drain();
        $display("covered %0d results: %0d hits, %0d evictions, %0d rejects, budgets 0..max",
                 n_results, n_hits, n_evictions, n_rejects);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("second_chance_byte_budget_cache_top: match");
        end else begin
            $display("second_chance_byte_budget_cache_top: mismatch");
        end
        $finish;
    end
endmodule

// File: files.f
src/scbb_pkg.sv
src/scbb_if.sv
src/scbb_dp.sv
src/scbb_ctrl.sv
src/second_chance_byte_budget_cache_top.sv
dv/tb_scbb_ifs.sv
dv/tb_top.sv
